>>> design/sequenced_source_deduplicating_deframer_unit_assert.svh
// Assertion macros for the deframer.
`ifndef SEQUENCED_SOURCE_DEDUPLICATING_DEFRAMER_UNIT_ASSERT_SVH
`define SEQUENCED_SOURCE_DEDUPLICATING_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define SSDD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSDD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ssdd_pkg.sv
`default_nettype none
package ssdd_pkg;

    localparam int SOURCE_SLOTS  = 16;
    localparam int RING_DEPTH    = 16;
    localparam int MAX_MSG_BYTES = 8;
    localparam int ID_BYTES      = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int SLOT_W = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int RING_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int EMIT_MAX = (RING_DEPTH < MAX_RESULTS) ? RING_DEPTH : MAX_RESULTS;
    localparam int ID_W = 8 * ID_BYTES;
    localparam int POS_W = 6;
    localparam int POS_MAX = (1 << POS_W) - 1;

    typedef enum logic [2:0] {
        ST_MSG     = 3'd0,
        ST_BAD_HDR = 3'd1,
        ST_NEW     = 3'd2,
        ST_DUP     = 3'd3,
        ST_BACK    = 3'd4,
        ST_FULL    = 3'd5,
        ST_SHORT   = 3'd6,
        ST_EMPTY   = 3'd7
    } status_t;

    typedef enum logic {
        REG_HDR_WORD = 1'b0,
        REG_HDR_LEN  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_READ,
        L_CMP
    } lk_state_t;

    typedef enum logic [2:0] {
        T_RUN,
        T_SCAN,
        T_ERD,
        T_EOUT,
        T_STAT
    } top_state_t;

    typedef struct packed {
        status_t             verdict;
        logic [SLOT_W-1:0]   slot;
        logic [7:0]          count;
    } lk_res_t;

endpackage
`default_nettype wire

>>> design/ssdd_lookup.sv
`default_nettype none
module ssdd_lookup
    import ssdd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [ID_W-1:0] id,
    input  wire logic [7:0]      seq,
    output logic                 done,
    output lk_res_t              res
);

    localparam int ENT_W = ID_W + 8;

    logic [ENT_W-1:0] src_mem [SOURCE_SLOTS];
    logic [ENT_W-1:0] rd_reg;

    lk_state_t         state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SOURCE_SLOTS-1:0] vld_reg, vld_next;
    logic              done_reg, done_next;
    lk_res_t           res_reg, res_next;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
    logic              hit;
    logic [7:0]        old_seq;

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = SOURCE_SLOTS - 1; i >= 0; i--)
        begin
            if (!vld_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign old_seq = rd_reg[7:0];
    assign hit     = vld_reg[idx_reg] && (rd_reg[ENT_W-1:8] == id);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        vld_next   = vld_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = L_READ;
                end
            end
            L_READ:
            begin
                state_next = L_CMP;
            end
            L_CMP:
            begin
                if (hit)
                begin
                    done_next     = 1'b1;
                    state_next    = L_IDLE;
                    res_next.slot = idx_reg;
                    res_next.count = 8'd0;
                    if (seq == old_seq)
                    begin
                        res_next.verdict = ST_DUP;
                    end
                    else if (seq < old_seq)
                    begin
                        res_next.verdict = ST_BACK;
                    end
                    else
                    begin
                        res_next.verdict = ST_MSG;
                        res_next.count   = seq - old_seq;
                        we               = 1'b1;
                    end
                end
                else if (idx_reg == SLOT_W'(SOURCE_SLOTS - 1))
                begin
                    done_next      = 1'b1;
                    state_next     = L_IDLE;
                    res_next.count = 8'd0;
                    if (free_ok)
                    begin
                        we                 = 1'b1;
                        waddr              = free_idx;
                        vld_next[free_idx] = 1'b1;
                        res_next.verdict   = ST_NEW;
                        res_next.slot      = free_idx;
                    end
                    else
                    begin
                        res_next.verdict = ST_FULL;
                        res_next.slot    = '0;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = L_READ;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            src_mem[waddr] <= {id, seq};
        end
        if (state_reg == L_READ)
        begin
            rd_reg <= src_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            idx_reg   <= '0;
            vld_reg   <= '0;
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            vld_reg   <= vld_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

>>> design/sequenced_source_deduplicating_deframer_unit.sv
// Channel  Dir  Handshake               Payload
// s_*      in   s_tvalid / s_tready     tdata: data_byte; tlast: last_byte
// m_*      out  m_tvalid / m_tready     tdata: bytes,len,src,status; tuser: trunc; tlast: last
// cfg_*    in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One datagram word per cycle while s_tready is high; it is low during a source search
// and while results go out. The sequence word starts a source search that holds s_tready
// low until a hit or the last slot (one source memory read and compare per slot).
// Each message result takes a ring memory read, then the output register; a status
// result only the output register, which lets a new datagram start while a result waits.
// No clearing pass after reset; source valid bits reset in flops.
`default_nettype none
`include "sequenced_source_deduplicating_deframer_unit_assert.svh"
module sequenced_source_deduplicating_deframer_unit
    import ssdd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [63:0] message_bytes, [71:64] message_length,
                                        // [75:72] source_index, [78:76] status, [79] zero
    output logic             m_tuser,   // [0] truncated
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int RENT_W = 72;

    logic [RENT_W-1:0] ring_mem [RING_DEPTH];
    logic [RENT_W-1:0] ring_rd_reg;

    logic [63:0] hdr_word_reg;
    logic [3:0]  hdr_len_reg;

    top_state_t        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           verdict_reg, verdict_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        newcnt_reg, newcnt_next;
    logic [7:0]        left_reg, left_next;
    logic [3:0]        bidx_reg, bidx_next;
    logic [7:0]        msgs_reg, msgs_next;
    logic [63:0]       cur_msg_reg, cur_msg_next;
    logic [7:0]        cur_len_reg, cur_len_next;
    logic [RING_W-1:0] head_reg, head_next;
    logic [7:0]        seq_reg, seq_next;
    logic              last_pend_reg, last_pend_next;
    status_t           stat_code_reg, stat_code_next;
    logic [3:0]        stat_src_reg, stat_src_next;
    logic [4:0]        emit_cnt_reg, emit_cnt_next;
    logic [RING_W-1:0] emit_slot_reg, emit_slot_next;

    logic              ovalid_reg, ovalid_next;
    logic [63:0]       obytes_reg, obytes_next;
    logic [7:0]        olen_reg, olen_next;
    logic              otrunc_reg, otrunc_next;
    logic [3:0]        osrc_reg, osrc_next;
    status_t           ostat_reg, ostat_next;
    logic              olast_reg, olast_next;

    logic              ring_we;
    logic [RING_W-1:0] ring_waddr;
    logic [RENT_W-1:0] ring_wdata;
    logic              ring_re;

    logic              lk_start;
    logic              lk_done;
    lk_res_t           lk_res;

    logic              in_fire;
    logic              out_free;
    logic [3:0]        hl;
    logic [POS_W-1:0]  id_end;
    logic [3:0]        sh4;
    logic [7:0]        want;
    logic [7:0]        b;
    logic [7:0]        cnt_a;
    logic [4:0]        cnt_c;

    ssdd_lookup u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lk_start),
        .id    (id_reg),
        .seq   (seq_reg),
        .done  (lk_done),
        .res   (lk_res)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_word_reg <= '0;
            hdr_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HDR_WORD: hdr_word_reg <= cfg_data;
                REG_HDR_LEN:  hdr_len_reg  <= cfg_data[3:0];
                default:      hdr_len_reg  <= hdr_len_reg;
            endcase
        end
    end

    assign s_tready = (state_reg == T_RUN);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign b        = s_tdata;
    assign hl       = (hdr_len_reg > 4'd8) ? 4'd8 : hdr_len_reg;
    assign id_end   = POS_W'(hl) + POS_W'(ID_BYTES);
    assign sh4      = hl - 4'd1 - pos_reg[3:0];
    assign want     = hdr_word_reg[{sh4[2:0], 3'b000} +: 8];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        id_next        = id_reg;
        verdict_next   = verdict_reg;
        slot_next      = slot_reg;
        newcnt_next    = newcnt_reg;
        left_next      = left_reg;
        bidx_next      = bidx_reg;
        msgs_next      = msgs_reg;
        cur_msg_next   = cur_msg_reg;
        cur_len_next   = cur_len_reg;
        head_next      = head_reg;
        seq_next       = seq_reg;
        last_pend_next = last_pend_reg;
        stat_code_next = stat_code_reg;
        stat_src_next  = stat_src_reg;
        emit_cnt_next  = emit_cnt_reg;
        emit_slot_next = emit_slot_reg;
        ovalid_next    = ovalid_reg && !m_tready;
        obytes_next    = obytes_reg;
        olen_next      = olen_reg;
        otrunc_next    = otrunc_reg;
        osrc_next      = osrc_reg;
        ostat_next     = ostat_reg;
        olast_next     = olast_reg;
        ring_we        = 1'b0;
        ring_waddr     = head_reg;
        ring_wdata     = '0;
        ring_re        = 1'b0;
        lk_start       = 1'b0;
        cnt_a          = 8'd0;
        cnt_c          = 5'd0;

        case (state_reg)
            T_RUN:
            begin
                if (in_fire)
                begin
                    if (pos_reg < POS_W'(hl))
                    begin
                        if (want != b)
                        begin
                            verdict_next = ST_BAD_HDR;
                        end
                    end
                    else if (verdict_reg == ST_BAD_HDR)
                    begin
                        verdict_next = ST_BAD_HDR;
                    end
                    else if (pos_reg < id_end)
                    begin
                        id_next = {id_reg[ID_W-9:0], b};
                    end
                    else if (pos_reg == id_end)
                    begin
                        seq_next       = b;
                        lk_start       = 1'b1;
                        last_pend_next = s_tlast;
                        state_next     = T_SCAN;
                    end
                    else if (verdict_reg == ST_MSG)
                    begin
                        if (left_reg == 8'd0)
                        begin
                            ring_we      = 1'b1;
                            ring_waddr   = head_reg;
                            ring_wdata   = {64'd0, b};
                            cur_msg_next = 64'd0;
                            cur_len_next = b;
                            left_next    = b;
                            bidx_next    = 4'd0;
                            head_next    = head_reg + 1'b1;
                            if (msgs_reg != 8'hFF)
                            begin
                                msgs_next = msgs_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            if (bidx_reg < 4'(MAX_MSG_BYTES))
                            begin
                                cur_msg_next[{3'd7 - bidx_reg[2:0], 3'b000} +: 8] = b;
                                bidx_next = bidx_reg + 4'd1;
                            end
                            left_next  = left_reg - 8'd1;
                            ring_we    = 1'b1;
                            ring_waddr = head_reg - 1'b1;
                            ring_wdata = {cur_msg_next, cur_len_reg};
                        end
                    end
                    if (pos_reg != POS_W'(POS_MAX))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end

                    if (s_tlast && !(pos_reg == id_end && verdict_reg != ST_BAD_HDR))
                    begin
                        state_next = T_STAT;
                        stat_src_next = 4'(slot_reg);
                        if (verdict_next == ST_BAD_HDR ||
                            ({1'b0, pos_reg} + 1'b1) < {1'b0, POS_W'(hl)})
                        begin
                            stat_code_next = ST_BAD_HDR;
                            stat_src_next  = 4'd0;
                        end
                        else if (pos_reg < id_end)
                        begin
                            stat_code_next = ST_SHORT;
                            stat_src_next  = 4'd0;
                        end
                        else if (verdict_reg != ST_MSG)
                        begin
                            stat_code_next = verdict_reg;
                            if (verdict_reg == ST_FULL)
                            begin
                                stat_src_next = 4'd0;
                            end
                        end
                        else if (msgs_next == 8'd0)
                        begin
                            stat_code_next = ST_EMPTY;
                        end
                        else
                        begin
                            cnt_a = (newcnt_reg < msgs_next) ? newcnt_reg : msgs_next;
                            cnt_c = (cnt_a > 8'(EMIT_MAX)) ? 5'(EMIT_MAX) : cnt_a[4:0];
                            emit_cnt_next  = cnt_c;
                            emit_slot_next = head_next - 1'b1;
                            state_next     = T_ERD;
                        end
                        pos_next     = '0;
                        id_next      = '0;
                        verdict_next = ST_MSG;
                        slot_next    = '0;
                        newcnt_next  = 8'd0;
                        left_next    = 8'd0;
                        bidx_next    = 4'd0;
                        msgs_next    = 8'd0;
                    end
                end
            end
            T_SCAN:
            begin
                if (lk_done)
                begin
                    verdict_next = lk_res.verdict;
                    slot_next    = lk_res.slot;
                    newcnt_next  = lk_res.count;
                    state_next   = T_RUN;
                    if (last_pend_reg)
                    begin
                        state_next     = T_STAT;
                        stat_code_next = (lk_res.verdict == ST_MSG) ? ST_EMPTY : lk_res.verdict;
                        stat_src_next  = (lk_res.verdict == ST_FULL) ? 4'd0 : 4'(lk_res.slot);
                        pos_next       = '0;
                        id_next        = '0;
                        verdict_next   = ST_MSG;
                        slot_next      = '0;
                        newcnt_next    = 8'd0;
                        left_next      = 8'd0;
                        bidx_next      = 4'd0;
                        msgs_next      = 8'd0;
                        last_pend_next = 1'b0;
                    end
                end
            end
            T_ERD:
            begin
                ring_re    = 1'b1;
                state_next = T_EOUT;
            end
            T_EOUT:
            begin
                if (out_free)
                begin
                    ovalid_next    = 1'b1;
                    obytes_next    = ring_rd_reg[71:8];
                    olen_next      = ring_rd_reg[7:0];
                    otrunc_next    = ring_rd_reg[7:0] > 8'(MAX_MSG_BYTES);
                    osrc_next      = stat_src_reg;
                    ostat_next     = ST_MSG;
                    olast_next     = (emit_cnt_reg == 5'd1);
                    emit_cnt_next  = emit_cnt_reg - 5'd1;
                    emit_slot_next = emit_slot_reg - 1'b1;
                    state_next     = (emit_cnt_reg == 5'd1) ? T_RUN : T_ERD;
                end
            end
            T_STAT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obytes_next = 64'd0;
                    olen_next   = 8'd0;
                    otrunc_next = 1'b0;
                    osrc_next   = stat_src_reg;
                    ostat_next  = stat_code_reg;
                    olast_next  = 1'b1;
                    state_next  = T_RUN;
                end
            end
            default:
            begin
                state_next = T_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[emit_slot_reg];
        end
        id_reg      <= id_next;
        cur_msg_reg <= cur_msg_next;
        cur_len_reg <= cur_len_next;
        seq_reg     <= seq_next;
        obytes_reg  <= obytes_next;
        olen_reg    <= olen_next;
        otrunc_reg  <= otrunc_next;
        osrc_reg    <= osrc_next;
        ostat_reg   <= ostat_next;
        olast_reg   <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_RUN;
            pos_reg       <= '0;
            verdict_reg   <= ST_MSG;
            slot_reg      <= '0;
            newcnt_reg    <= '0;
            left_reg      <= '0;
            bidx_reg      <= '0;
            msgs_reg      <= '0;
            head_reg      <= '0;
            last_pend_reg <= 1'b0;
            stat_code_reg <= ST_MSG;
            stat_src_reg  <= '0;
            emit_cnt_reg  <= '0;
            emit_slot_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            verdict_reg   <= verdict_next;
            slot_reg      <= slot_next;
            newcnt_reg    <= newcnt_next;
            left_reg      <= left_next;
            bidx_reg      <= bidx_next;
            msgs_reg      <= msgs_next;
            head_reg      <= head_next;
            last_pend_reg <= last_pend_next;
            stat_code_reg <= stat_code_next;
            stat_src_reg  <= stat_src_next;
            emit_cnt_reg  <= emit_cnt_next;
            emit_slot_reg <= emit_slot_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, ostat_reg, osrc_reg, olen_reg, obytes_reg};
    assign m_tuser  = otrunc_reg;
    assign m_tlast  = olast_reg;

    `SSDD_ASSERT_IMP(a_done_in_scan, lk_done, state_reg == T_SCAN, "lookup done outside scan")
    `SSDD_ASSERT_IMP(a_emit_nonzero, state_reg == T_ERD || state_reg == T_EOUT,
        emit_cnt_reg != 5'd0, "emit with zero count")
    `SSDD_ASSERT_IMP(a_status_last, m_tvalid && ostat_reg != ST_MSG, m_tlast,
        "status result not last")
    `SSDD_ASSERT_NXT(a_scan_hold, state_reg == T_SCAN && !lk_done, !s_tready,
        "input taken during scan")

endmodule
`default_nettype wire

>>> test/tb_sequenced_source_deduplicating_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sequenced_source_deduplicating_deframer_unit;
    import ssdd_pkg::*;

    localparam int LIMIT  = 50000;
    localparam int NO_CHK = 8;
    localparam int N_IDS  = 20;
    localparam int ITEMS  = 180;

    typedef struct {
        logic [63:0] bytes;
        logic [7:0]  len;
        logic        trunc;
        logic [3:0]  src;
        logic [2:0]  st;
        logic        last;
    } deframe_res_t;

    typedef struct {
        bit  hdr_ok;
        int  id;
        int  cut;
        int  seq;
        int  nmsg;
        int  maxlen;
        int  exp_st;
    } gram_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_HDR_WORD;
    logic [63:0] cfg_data = '0;

    sequenced_source_deduplicating_deframer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor copy of the block
    logic [63:0]  hdr_word = '0;
    logic [3:0]   hdr_len = '0;
    logic [63:0]  tab_hi [SOURCE_SLOTS];
    logic [63:0]  tab_lo [SOURCE_SLOTS];
    logic [7:0]   tab_seq [SOURCE_SLOTS];
    bit           tab_vld [SOURCE_SLOTS];
    int           pos = 0;
    logic [63:0]  acc_hi = '0, acc_lo = '0;
    status_t      verdict = ST_MSG;
    logic [3:0]   cur_slot = '0;
    logic [7:0]   new_cnt = '0, left_cnt = '0, msg_cnt = '0;
    logic [63:0]  ring_data [RING_DEPTH];
    logic [7:0]   ring_len [RING_DEPTH];
    logic [3:0]   ring_head = '0;

    deframe_res_t expected_q [$];
    int           first_st;
    int           errors = 0;
    int           cycles = 0;
    int           sent_words = 0;
    bit           quiet = 0;
    logic [127:0] ids [N_IDS];
    int           last_seq [N_IDS];

    task automatic push_res(logic [63:0] bytes, logic [7:0] len, logic trunc,
                            logic [3:0] src, logic [2:0] st, logic last);
        deframe_res_t r;
        r.bytes = bytes; r.len = len; r.trunc = trunc; r.src = src; r.st = st;
        r.last = last;
        if (first_st < 0)
            first_st = st;
        expected_q.push_back(r);
    endtask

    task automatic clear_gram();
        pos = 0; acc_hi = '0; acc_lo = '0; verdict = ST_MSG; cur_slot = '0;
        new_cnt = '0; left_cnt = '0; msg_cnt = '0;
    endtask

    task automatic predict_word(logic [7:0] b, bit last);
        int hl, p, fs, cnt, sl, idx;
        bit found;
        logic [7:0] want;
        logic [3:0] ws;
        hl = (hdr_len > 8) ? 8 : hdr_len;
        p = pos;
        if (p < hl)
        begin
            want = 8'(hdr_word >> (8 * (hl - 1 - p)));
            if (want != b)
                verdict = ST_BAD_HDR;
        end
        else if (verdict == ST_BAD_HDR)
        begin
        end
        else if (p < hl + ID_BYTES)
        begin
            acc_hi = {acc_hi[55:0], acc_lo[63:56]};
            acc_lo = {acc_lo[55:0], b};
        end
        else if (p == hl + ID_BYTES)
        begin
            found = 0;
            fs = SOURCE_SLOTS;
            for (int i = 0; i < SOURCE_SLOTS; i++)
            begin
                if (!found)
                begin
                    if (tab_vld[i] && tab_hi[i] == acc_hi && tab_lo[i] == acc_lo)
                    begin
                        found = 1;
                        cur_slot = 4'(i);
                        if (b == tab_seq[i])
                            verdict = ST_DUP;
                        else if (b < tab_seq[i])
                            verdict = ST_BACK;
                        else
                        begin
                            new_cnt = b - tab_seq[i];
                            tab_seq[i] = b;
                            verdict = ST_MSG;
                        end
                    end
                    else if (!tab_vld[i] && fs == SOURCE_SLOTS)
                        fs = i;
                end
            end
            if (!found)
            begin
                if (fs == SOURCE_SLOTS)
                    verdict = ST_FULL;
                else
                begin
                    tab_vld[fs] = 1; tab_hi[fs] = acc_hi; tab_lo[fs] = acc_lo;
                    tab_seq[fs] = b; cur_slot = 4'(fs); verdict = ST_NEW;
                end
            end
        end
        else if (verdict == ST_MSG)
        begin
            if (left_cnt == 0)
            begin
                ring_data[ring_head] = '0;
                ring_len[ring_head] = b;
                left_cnt = b;
                ring_head = ring_head + 4'd1;
                if (msg_cnt < 255)
                    msg_cnt++;
            end
            else
            begin
                ws = ring_head - 4'd1;
                idx = ring_len[ws] - left_cnt;
                if (idx < MAX_MSG_BYTES)
                    ring_data[ws] = ring_data[ws] | (64'(b) << (56 - 8 * idx));
                left_cnt--;
            end
        end
        if (pos < 65535)
            pos++;
        if (!last)
            return;
        if (verdict == ST_BAD_HDR || p + 1 < hl)
            push_res('0, '0, 0, '0, ST_BAD_HDR, 1);
        else if (p < hl + ID_BYTES)
            push_res('0, '0, 0, '0, ST_SHORT, 1);
        else if (verdict != ST_MSG)
            push_res('0, '0, 0, (verdict == ST_FULL) ? 4'd0 : cur_slot, verdict, 1);
        else if (msg_cnt == 0)
            push_res('0, '0, 0, cur_slot, ST_EMPTY, 1);
        else
        begin
            cnt = new_cnt;
            if (cnt > msg_cnt) cnt = msg_cnt;
            if (cnt > RING_DEPTH) cnt = RING_DEPTH;
            if (cnt > MAX_RESULTS) cnt = MAX_RESULTS;
            sl = ring_head;
            for (int k = 0; k < cnt; k++)
            begin
                sl = (sl + RING_DEPTH - 1) % RING_DEPTH;
                push_res(ring_data[sl], ring_len[sl], ring_len[sl] > MAX_MSG_BYTES,
                         cur_slot, ST_MSG, k + 1 == cnt);
            end
        end
        clear_gram();
    endtask

    task automatic send_word(logic [7:0] b, bit last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sent_words++;
        predict_word(b, last);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_HDR_WORD)
            hdr_word = val;
        else
            hdr_len = val[3:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_gram(gram_row_t g);
        logic [7:0] q [$];
        int hl, n, bad;
        logic [7:0] len;
        hl = (hdr_len > 8) ? 8 : hdr_len;
        for (int i = 0; i < hl; i++)
            q.push_back(8'(hdr_word >> (8 * (hl - 1 - i))));
        if (!g.hdr_ok && hl > 0)
        begin
            bad = $urandom_range(0, hl - 1);
            q[bad] = q[bad] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < ID_BYTES; i++)
            q.push_back(8'(ids[g.id] >> (8 * (ID_BYTES - 1 - i))));
        q.push_back(8'(g.seq));
        for (int m = 0; m < g.nmsg; m++)
        begin
            len = 8'($urandom_range(0, g.maxlen));
            q.push_back(len);
            for (int i = 0; i < len; i++)
                q.push_back(8'($urandom_range(0, 255)));
        end
        n = (g.cut > 0 && g.cut < q.size()) ? g.cut : q.size();
        first_st = -1;
        for (int i = 0; i < n; i++)
            send_word(q[i], i == n - 1);
        s_tvalid <= 1'b0;
        @(posedge clk);
        if (g.exp_st != NO_CHK && first_st != g.exp_st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, g.exp_st, first_st);
            errors++;
        end
        if (g.seq > last_seq[g.id])
            last_seq[g.id] = g.seq;
    endtask

    task automatic random_phase(int grams);
        gram_row_t g;
        int r;
        for (int n = 0; n < grams; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                quiet = !quiet;
            g.id = $urandom_range(0, N_IDS - 1);
            g.hdr_ok = $urandom_range(0, 9) != 0;
            g.cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
            r = $urandom_range(0, 9);
            if (r < 7 && last_seq[g.id] < 250)
                g.seq = last_seq[g.id] + $urandom_range(1, 4);
            else if (r == 7)
                g.seq = last_seq[g.id];
            else
                g.seq = $urandom_range(0, 255);
            g.nmsg = $urandom_range(0, 3);
            g.maxlen = ($urandom_range(0, 19) == 0) ? 20 : 10;
            g.exp_st = NO_CHK;
            send_gram(g);
        end
    endtask

    gram_row_t directed [9] = '{
        '{0, 0, 3, 5, 0, 0, ST_BAD_HDR},
        '{1, 0, 1, 5, 0, 0, ST_BAD_HDR},
        '{1, 0, 10, 5, 0, 0, ST_SHORT},
        '{1, 0, 0, 5, 0, 0, ST_NEW},
        '{1, 0, 0, 5, 1, 4, ST_DUP},
        '{1, 0, 0, 3, 0, 0, ST_BACK},
        '{1, 0, 0, 8, 2, 12, NO_CHK},
        '{1, 0, 0, 9, 0, 0, ST_EMPTY},
        '{1, 0, 0, 255, 17, 0, NO_CHK}
    };

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_sequenced_source_deduplicating_deframer_unit: FAIL");
            $finish;
        end
    end

    int rx_stall = 0;
    always @(posedge clk)
    begin
        deframe_res_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_q[0];
                expected_q.delete(0);
                if (m_tdata[63:0] !== e.bytes || m_tdata[71:64] !== e.len ||
                    m_tuser !== e.trunc || m_tdata[75:72] !== e.src ||
                    m_tdata[78:76] !== e.st || m_tlast !== e.last)
                begin
                    $display("%0t: expected bytes %h len %0d tr %0d src %0d st %0d last %0d",
                             $time, e.bytes, e.len, e.trunc, e.src, e.st, e.last);
                    $display("%0t: actual   bytes %h len %0d tr %0d src %0d st %0d last %0d",
                             $time, m_tdata[63:0], m_tdata[71:64], m_tuser,
                             m_tdata[75:72], m_tdata[78:76], m_tlast);
                    errors++;
                end
            end
            rx_stall = quiet ? 0 : $urandom_range(0, 13);
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        for (int i = 0; i < SOURCE_SLOTS; i++)
            tab_vld[i] = 0;
        for (int i = 0; i < N_IDS; i++)
        begin
            ids[i] = {$urandom, $urandom, $urandom, $urandom};
            last_seq[i] = 0;
        end
        ids[1] = '1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_HDR_WORD, 64'h0000_0000_0000_A55A);
        write_reg(REG_HDR_LEN, 64'd2);
        foreach (directed[i])
            send_gram(directed[i]);

        for (int ph = 0; sent_words < ITEMS; ph++)
        begin
            wait_idle();
            case (ph % 4)
                0:
                begin
                    write_reg(REG_HDR_WORD, '1);
                    write_reg(REG_HDR_LEN, 64'd8);
                end
                1:
                begin
                    write_reg(REG_HDR_WORD, {$urandom, $urandom});
                    write_reg(REG_HDR_LEN, 64'd15);
                end
                2:
                begin
                    write_reg(REG_HDR_WORD, 64'd0);
                    write_reg(REG_HDR_LEN, 64'd0);
                end
                default:
                begin
                    write_reg(REG_HDR_WORD, {$urandom, $urandom});
                    write_reg(REG_HDR_LEN, 64'd3);
                end
            endcase
            random_phase(1);
        end

        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_sequenced_source_deduplicating_deframer_unit: PASS");
        else
            $display("tb_sequenced_source_deduplicating_deframer_unit: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/ssdd_pkg.sv
design/ssdd_lookup.sv
design/sequenced_source_deduplicating_deframer_unit.sv
test/tb_sequenced_source_deduplicating_deframer_unit.sv
